// ===== hw/rtl/ets_pkg.sv =====
`timescale 1ns / 1ps

package ets_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int COUNT_WIDTH  = 16;
   localparam int CMP_W        = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int PTR_W        = $clog2(QUEUE_DEPTH);
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [7:0] CHAN_MASK = 8'((1 << NUM_CHANNELS) - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIG_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIG_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT   = 2'd2;

   localparam logic [7:0]  TRIG_LOW_RESET  = 8'd2;
   localparam logic [7:0]  TRIG_HIGH_RESET = 8'd10;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd30000;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOW,
      PH_HIGH,
      PH_MEASURE
   } phase_type;

   typedef struct packed {
      logic       start_req;
      logic [7:0] enable_mask;
      logic [7:0] echo_pins;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  channel;
      logic [15:0] elapsed;
      logic [7:0]  trigger_pins;
      logic        busy_res;
      logic        timed_out;
      logic        last;
   } rsp_type;

   // one processed tick waiting for the result side
   typedef struct packed {
      logic [7:0]  fall;
      logic [15:0] elapsed;
      logic [7:0]  trig;
      logic        busy;
      logic        timed_out;
   } tick_rec_type;

endpackage

// ===== hw/rtl/multichannel_echo_timer.sv =====
`timescale 1ns / 1ps
// Channel  Ports                               Direction  Moves
// req      req_valid  req_stall  req_data      in         one tick of echo samples
// rsp      rsp_valid  rsp_stall  rsp_data      out        capture and status results
// csr      csr_we  csr_index  csr_wdata        in         trigger and timeout settings
//
// A tick is taken every cycle while the 4-entry tick queue has room; the front
// updates the trigger sequence in the same cycle it takes the tick.
// The result register issues one result a cycle while rsp_stall is low; a tick
// yields a result per capture plus a status; the queue absorbs bursts of captures.
// Synchronous reset returns the settings to their defaults and the sequencer to idle.
// req_stall rises only when the queue is full; rsp_stall holds the result register.

module multichannel_echo_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ets_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ets_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [ets_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ets_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ets_pkg::*;

   tick_rec_type rec;
   tick_rec_type head;
   logic         q_empty;
   logic         q_full;
   logic         q_pop;
   logic         accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   ets_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rec       (rec)
   );

   ets_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rec),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   ets_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (q_empty),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/ets_front.sv =====
`timescale 1ns / 1ps

module ets_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  ets_pkg::req_type                    req_data,
   input  logic                                csr_we,
   input  logic [ets_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ets_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ets_pkg::tick_rec_type               rec
);
   import ets_pkg::*;

   logic [7:0]             trig_low_ff;
   logic [7:0]             trig_high_ff;
   logic [15:0]            timeout_ff;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [7:0]             ena_ff, ena_in;
   logic [7:0]             seen_ff, seen_in;
   logic [7:0]             fin_ff, fin_in;

   logic [7:0]             high_eff;
   logic [7:0]             echo;
   logic [7:0]             live_w;
   logic [7:0]             fall_w;
   logic [7:0]             trig_w;
   logic                   to_w;
   logic [COUNT_WIDTH-1:0] el_w;
   logic [CMP_W-1:0]       el_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_low_ff  <= TRIG_LOW_RESET;
         trig_high_ff <= TRIG_HIGH_RESET;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRIG_LOW:  trig_low_ff  <= csr_wdata[7:0];
            CSR_TRIG_HIGH: trig_high_ff <= csr_wdata[7:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign high_eff = (trig_high_ff == 8'd0) ? 8'd1 : trig_high_ff;
   assign echo     = req_data.echo_pins & CHAN_MASK;

   // next state: the phases can chain within one tick
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      ena_in   = ena_ff;
      seen_in  = seen_ff;
      fin_in   = fin_ff;
      live_w   = '0;
      fall_w   = '0;
      trig_w   = '0;
      to_w     = 1'b0;
      el_w     = '0;
      if (accept) begin
         if (phase_ff == PH_IDLE && req_data.start_req) begin
            ena_in   = req_data.enable_mask & CHAN_MASK;
            seen_in  = '0;
            fin_in   = '0;
            cnt_in   = '0;
            phase_in = PH_LOW;
         end
         if (phase_in == PH_LOW) begin
            if (cnt_in < COUNT_WIDTH'(trig_low_ff)) begin
               cnt_in = cnt_in + 1'b1;
            end else begin
               phase_in = PH_HIGH;
               cnt_in   = '0;
            end
         end
         if (phase_in == PH_HIGH) begin
            trig_w = ena_in;
            cnt_in = cnt_in + 1'b1;
            if (cnt_in >= COUNT_WIDTH'(high_eff)) begin
               phase_in = PH_MEASURE;
               cnt_in   = '0;
            end
         end else if (phase_in == PH_MEASURE) begin
            if (cnt_in == COUNT_MAX) begin
               // counter pinned at its top: give up
               to_w     = 1'b1;
               el_w     = cnt_in;
               phase_in = PH_IDLE;
            end else begin
               el_w   = cnt_in + 1'b1;
               cnt_in = el_w;
               if (CMP_W'(el_w) > CMP_W'(timeout_ff)) begin
                  to_w     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  live_w  = ena_in & ~fin_in;
                  fall_w  = live_w & seen_in & ~echo;
                  seen_in = seen_in | (live_w & echo);
                  fin_in  = fin_in | fall_w;
                  if ((fin_in & ena_in) == ena_in) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            if (phase_in == PH_IDLE) begin
               cnt_in = '0;
            end
         end
      end
   end

   assign el_ext = CMP_W'(el_w);

   always_comb begin
      rec.fall      = fall_w;
      rec.elapsed   = el_ext[15:0];
      rec.trig      = trig_w;
      rec.busy      = (phase_in != PH_IDLE);
      rec.timed_out = to_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         ena_ff   <= '0;
         seen_ff  <= '0;
         fin_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         ena_ff   <= ena_in;
         seen_ff  <= seen_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

// ===== hw/rtl/ets_queue.sv =====
`timescale 1ns / 1ps

module ets_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ets_pkg::tick_rec_type push_data,
   input  logic                  pop,
   output ets_pkg::tick_rec_type head,
   output logic                  empty,
   output logic                  full
);
   import ets_pkg::*;

   tick_rec_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== hw/rtl/ets_back.sv =====
`timescale 1ns / 1ps

module ets_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ets_pkg::tick_rec_type head,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ets_pkg::rsp_type      rsp_data
);
   import ets_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [7:0] done_ff, done_in;
   logic [7:0] remain;
   logic [7:0] low_bit;
   logic [2:0] low_idx;
   logic       load;

   assign remain  = head.fall & ~done_ff;
   assign low_bit = remain & (~remain + 8'd1);

   always_comb begin
      low_idx = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (remain[i]) begin
            low_idx = 3'(i);
         end
      end
   end

   // output register frees up when empty or taken this cycle
   assign load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      done_in      = done_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in             = !empty;
         rsp_data_in.elapsed      = head.elapsed;
         rsp_data_in.trigger_pins = head.trig;
         rsp_data_in.busy_res     = head.busy;
         if (remain != 8'd0) begin
            // captures first, lowest channel first
            rsp_data_in.kind      = 1'b1;
            rsp_data_in.channel   = low_idx;
            rsp_data_in.timed_out = 1'b0;
            rsp_data_in.last      = 1'b0;
            if (!empty) begin
               done_in = done_ff | low_bit;
            end
         end else begin
            rsp_data_in.kind      = 1'b0;
            rsp_data_in.channel   = '0;
            rsp_data_in.timed_out = head.timed_out;
            rsp_data_in.last      = 1'b1;
            if (!empty) begin
               pop     = 1'b1;
               done_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/ets_checker.sv =====
`timescale 1ns / 1ps

module ets_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ets_pkg::rsp_type rsp_data
);
   import ets_pkg::*;

   // nothing left over in the result register after reset
   a_reset_clears_rsp : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an empty queue after reset takes ticks at once
   a_reset_frees_req : assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("tick stalled right after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a timeout ends the run, and only the status carries it
   a_timeout_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.timed_out |->
         !rsp_data.busy_res && !rsp_data.kind && rsp_data.last)
      else $error("timeout result malformed");

endmodule

bind multichannel_echo_timer ets_checker u_ets_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
